/* rtl/core/mte_pkg.sv */
package mte_pkg;

  // Escape buffer geometry
  localparam int ESCAPE_DEPTH = 16;
  localparam int ESC_AW       = (ESCAPE_DEPTH > 1) ? $clog2(ESCAPE_DEPTH) : 1;
  localparam int ESC_CW       = $clog2(ESCAPE_DEPTH + 1);

  // Line tag number and its accumulator
  localparam int TAG_W = 7;
  localparam int ACC_W = TAG_W + 4;
  localparam logic [TAG_W-1:0] TAG_MAX = 7'd99;
  localparam logic [TAG_W-1:0] TAG_SAT = 7'd100;
  localparam logic [3:0]       TAG_RADIX = 4'd10;

  // Characters
  localparam logic [7:0] CH_ESC    = 8'h1B;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LT     = 8'h3C;
  localparam logic [7:0] CH_GT     = 8'h3E;
  localparam logic [7:0] CH_LBRACK = 8'h5B;
  localparam logic [7:0] CH_SEMI   = 8'h3B;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;
  localparam logic [7:0] CH_LOW_A  = 8'h61;
  localparam logic [7:0] CH_LOW_Z  = 8'h7A;
  localparam logic [7:0] CH_UP_A   = 8'h41;
  localparam logic [7:0] CH_UP_Z   = 8'h5A;
  localparam logic [7:0] CH_DQUOTE = 8'h22;
  localparam logic [7:0] CH_SQUOTE = 8'h27;
  localparam logic [7:0] CH_DASH   = 8'h2D;
  localparam logic [7:0] CH_BANG   = 8'h21;

  typedef enum logic [2:0] {
    SC_TEXT    = 3'd0,
    SC_ESC     = 3'd1,
    SC_TAG     = 3'd2,
    SC_COMMENT = 3'd3,
    SC_QUOTE   = 3'd4
  } scan_e;

  typedef enum logic [2:0] {
    KIND_TEXT        = 3'd0,
    KIND_TEXT_END    = 3'd1,
    KIND_NEWLINE     = 3'd2,
    KIND_TAG_BYTE    = 3'd3,
    KIND_TAG_END     = 3'd4,
    KIND_TAG_DISCARD = 3'd5,
    KIND_LINE_TAG    = 3'd6,
    KIND_ERROR       = 3'd7
  } kind_e;

  typedef enum logic [1:0] {
    ERR_ESC      = 2'd0,
    ERR_TAG      = 2'd1,
    ERR_COMMENT  = 2'd2,
    ERR_LINE_TAG = 2'd3
  } err_e;

  typedef enum logic [2:0] {
    SQ_IDLE   = 3'd0,
    SQ_ERR    = 3'd1,
    SQ_NL     = 3'd2,
    SQ_REPLAY = 3'd3,
    SQ_TAGS   = 3'd4
  } seq_e;

  typedef struct packed {
    logic clear;
    logic step;
  } acc_ctl_t;

  // Opening characters of a comment tag
  function automatic logic [7:0] comment_char(input logic [1:0] pos);
    logic [7:0] ch;
    unique case (pos)
      2'd0:    ch = CH_BANG;
      default: ch = CH_DASH;
    endcase
    return ch;
  endfunction

endpackage

/* rtl/core/mte_ram.sv */
module mte_ram #(
  parameter int Width = 8,
  parameter int Depth = 16
) (
  input  logic                                  clk_i,
  input  logic                                  we_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] waddr_i,
  input  logic [Width-1:0]                      wdata_i,
  input  logic [((Depth > 1) ? $clog2(Depth) : 1)-1:0] raddr_i,
  output logic [Width-1:0]                      rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

/* rtl/core/mte_tag_acc.sv */
module mte_tag_acc
  import mte_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  acc_ctl_t         ctl_i,
  input  logic [7:0]       char_i,
  output logic [TAG_W-1:0] num_o
);

  logic [TAG_W-1:0] num_q, num_d;
  logic [7:0]       digit;
  logic [ACC_W-1:0] sum;

  // num * 10 + digit, saturating just above the largest legal tag
  always_comb begin
    digit = char_i - CH_ZERO;
    sum   = ACC_W'(num_q) * ACC_W'(TAG_RADIX) + ACC_W'(digit);
    num_d = num_q;
    if (ctl_i.clear) begin
      num_d = '0;
    end else if (ctl_i.step) begin
      num_d = (sum > ACC_W'(TAG_MAX)) ? TAG_SAT : sum[TAG_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_q <= '0;
    end else begin
      num_q <= num_d;
    end
  end

  assign num_o = num_q;

endmodule

/* rtl/core/markup_and_escape_tokenizer_top.sv */
// Markup and escape tokenizer. Each request on the input channel carries one
// received byte; the block classifies it as text, escape sequence, markup tag,
// comment or quoted tag parameter, and issues zero or more result requests,
// the final one of each byte flagged by last_o. A byte that gives at most one
// result leaves the sequencer idle, so plain text and tag bytes stream at one
// byte per clock as long as the output side keeps up. Bytes that give several
// results keep in_stall_o high while the sequencer issues them one after
// another through the single output register: a broken tag with a line feed
// gives a discard, an error and a newline result, a replayed escape sequence
// gives ESC, the buffer read out of the escape RAM one entry per cycle while
// the output side keeps up, then the terminating byte, and ESC [ ... z has the
// shared multiply-by-ten unit fold one buffered digit per cycle into the line tag
// number. The escape RAM needs no clearing pass after reset: only entries
// below the fill count are read. locked_mode may be written only while the
// block is idle; when set, '<' is taken as plain text.
module markup_and_escape_tokenizer_top
  import mte_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  // configuration
  input  logic             cfg_we_i,
  input  logic             cfg_wdata_i,
  // byte input
  input  logic             in_valid_i,
  output logic             in_stall_o,
  input  logic [7:0]       byte_in_i,
  // results
  output logic             out_valid_o,
  input  logic             out_stall_i,
  output logic [2:0]       kind_o,
  output logic [7:0]       value_o,
  output logic [TAG_W-1:0] line_tag_o,
  output logic [1:0]       error_code_o,
  output logic             last_o
);

  // Everything decided when a byte is taken in the idle state
  typedef struct packed {
    logic              em;
    kind_e             kind;
    logic [7:0]        value;
    err_e              err;
    logic              last;
    seq_e              nxt;
    logic              nl;
    scan_e             scan;
    logic              pend;
    logic [ESC_CW-1:0] cnt;
    logic [7:0]        quote;
    logic [2:0]        len;
    logic              cpo;
    logic [15:0]       last2;
    logic              we;
  } plan_t;

  // Scanner state
  scan_e             scan_q, scan_d;
  logic              pend_q, pend_d;
  logic [ESC_CW-1:0] esc_cnt_q, esc_cnt_d;
  logic [7:0]        quote_q, quote_d;
  logic [2:0]        tag_len_q, tag_len_d;
  logic              cpo_q, cpo_d;
  logic [15:0]       last2_q, last2_d;
  logic              locked_q;

  // Sequencer state
  seq_e              seq_q, seq_d;
  logic [ESC_CW-1:0] idx_q, idx_d;
  logic [7:0]        byte_q, byte_d;
  logic              nl_q, nl_d;

  // Output register
  logic              out_valid_q, out_valid_d;
  kind_e             kind_q, kind_d;
  logic [7:0]        value_q, value_d;
  logic [TAG_W-1:0]  tag_q, tag_d;
  err_e              err_q, err_d;
  logic              last_q, last_d;

  plan_t             plan;
  logic              slot_free;
  logic              accept;
  logic              in_run;
  logic              brk;
  logic              do_break;
  logic              replay;
  logic              store;
  logic              append;
  logic              em;
  kind_e             em_kind;
  logic [7:0]        em_value;
  logic [TAG_W-1:0]  em_tag;
  err_e              em_err;
  logic              em_last;
  logic              fire;
  acc_ctl_t          acc_ctl;
  logic [TAG_W-1:0]  acc_num;
  logic [7:0]        ram_rdata;

  assign slot_free  = !out_valid_q || !out_stall_i;
  assign in_stall_o = (seq_q != SQ_IDLE) || !slot_free;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_run     = idx_q < esc_cnt_q;
  assign brk        = (byte_in_i == CH_ESC) || (byte_in_i == CH_LF) || (byte_in_i == CH_CR);

  // Classify the incoming byte against the scan state
  always_comb begin
    plan.em    = 1'b0;
    plan.kind  = KIND_TEXT;
    plan.value = '0;
    plan.err   = ERR_ESC;
    plan.last  = 1'b1;
    plan.nxt   = SQ_IDLE;
    plan.nl    = 1'b0;
    plan.scan  = scan_q;
    plan.pend  = pend_q;
    plan.cnt   = esc_cnt_q;
    plan.quote = quote_q;
    plan.len   = tag_len_q;
    plan.cpo   = cpo_q;
    plan.last2 = last2_q;
    plan.we    = 1'b0;
    do_break   = 1'b0;
    replay     = 1'b0;
    store      = 1'b0;
    append     = 1'b0;

    unique case (scan_q)
      SC_ESC: begin
        if (brk) begin
          plan.em   = 1'b1;
          plan.kind = KIND_ERROR;
          plan.err  = ERR_ESC;
          do_break  = 1'b1;
          if (byte_in_i == CH_LF) begin
            plan.last = 1'b0;
            plan.nxt  = SQ_NL;
          end
        end else if ((byte_in_i >= CH_LOW_A && byte_in_i <= CH_LOW_Z) ||
                     (byte_in_i >= CH_UP_A && byte_in_i <= CH_UP_Z)) begin
          if (byte_in_i == CH_LOW_Z && esc_cnt_q != '0) begin
            // walk the buffer for line tags, clear the count at the end
            plan.nxt  = SQ_TAGS;
            plan.scan = SC_TEXT;
          end else begin
            replay = 1'b1;
          end
        end else if (byte_in_i == CH_LBRACK) begin
          if (esc_cnt_q == '0) begin
            store = 1'b1;
          end else begin
            replay = 1'b1;
          end
        end else if (byte_in_i == CH_SEMI ||
                     (byte_in_i >= CH_ZERO && byte_in_i <= CH_NINE)) begin
          if (esc_cnt_q != '0) begin
            store = 1'b1;
          end else begin
            replay = 1'b1;
          end
        end else begin
          replay = 1'b1;
        end
      end

      SC_TAG: begin
        if (byte_in_i == CH_GT) begin
          plan.em   = 1'b1;
          plan.kind = KIND_TAG_END;
          plan.len  = '0;
          plan.cpo  = 1'b0;
          plan.scan = SC_TEXT;
        end else if (byte_in_i == CH_DQUOTE || byte_in_i == CH_SQUOTE) begin
          plan.em    = 1'b1;
          plan.kind  = KIND_TAG_BYTE;
          plan.value = byte_in_i;
          plan.quote = byte_in_i;
          plan.scan  = SC_QUOTE;
          append     = 1'b1;
        end else if (brk) begin
          plan.em   = 1'b1;
          plan.kind = KIND_TAG_DISCARD;
          plan.last = 1'b0;
          plan.nxt  = SQ_ERR;
          plan.nl   = (byte_in_i == CH_LF);
          do_break  = 1'b1;
        end else if (tag_len_q == 3'd3 && cpo_q) begin
          // comment opener seen: drop what was streamed
          plan.em    = 1'b1;
          plan.kind  = KIND_TAG_DISCARD;
          plan.last2 = {CH_DASH, byte_in_i};
          plan.len   = '0;
          plan.cpo   = 1'b0;
          plan.scan  = SC_COMMENT;
        end else begin
          plan.em    = 1'b1;
          plan.kind  = KIND_TAG_BYTE;
          plan.value = byte_in_i;
          append     = 1'b1;
        end
      end

      SC_COMMENT: begin
        if (byte_in_i == CH_GT && last2_q == {CH_DASH, CH_DASH}) begin
          plan.last2 = '0;
          plan.scan  = SC_TEXT;
        end else if (brk) begin
          plan.em    = 1'b1;
          plan.kind  = KIND_ERROR;
          plan.err   = ERR_COMMENT;
          plan.last2 = '0;
          do_break   = 1'b1;
          if (byte_in_i == CH_LF) begin
            plan.last = 1'b0;
            plan.nxt  = SQ_NL;
          end
        end else begin
          plan.last2 = {last2_q[7:0], byte_in_i};
        end
      end

      SC_QUOTE: begin
        if (byte_in_i == quote_q) begin
          plan.em    = 1'b1;
          plan.kind  = KIND_TAG_BYTE;
          plan.value = byte_in_i;
          plan.scan  = SC_TAG;
          append     = 1'b1;
        end else if (brk) begin
          plan.em   = 1'b1;
          plan.kind = KIND_TAG_DISCARD;
          plan.last = 1'b0;
          plan.nxt  = SQ_ERR;
          plan.nl   = (byte_in_i == CH_LF);
          do_break  = 1'b1;
        end else begin
          plan.em    = 1'b1;
          plan.kind  = KIND_TAG_BYTE;
          plan.value = byte_in_i;
          append     = 1'b1;
        end
      end

      default: begin
        // text state; unused codes behave the same
        plan.scan = SC_TEXT;
        if (brk || (byte_in_i == CH_LT && !locked_q)) begin
          plan.pend = 1'b0;
          if (byte_in_i == CH_ESC) begin
            plan.cnt  = '0;
            plan.scan = SC_ESC;
          end else if (byte_in_i == CH_LT) begin
            plan.len  = '0;
            plan.cpo  = 1'b1;
            plan.scan = SC_TAG;
          end
          if (pend_q) begin
            plan.em   = 1'b1;
            plan.kind = KIND_TEXT_END;
            if (byte_in_i == CH_LF) begin
              plan.last = 1'b0;
              plan.nxt  = SQ_NL;
            end
          end else if (byte_in_i == CH_LF) begin
            plan.em   = 1'b1;
            plan.kind = KIND_NEWLINE;
          end
        end else begin
          plan.em    = 1'b1;
          plan.kind  = KIND_TEXT;
          plan.value = byte_in_i;
          plan.pend  = 1'b1;
        end
      end
    endcase

    if (store) begin
      if (esc_cnt_q >= ESC_CW'(ESCAPE_DEPTH)) begin
        replay = 1'b1;
      end else begin
        plan.we  = 1'b1;
        plan.cnt = esc_cnt_q + 1'b1;
      end
    end

    // replay: ESC now, buffer and byte from the sequencer
    if (replay) begin
      plan.em    = 1'b1;
      plan.kind  = KIND_TEXT;
      plan.value = CH_ESC;
      plan.last  = 1'b0;
      plan.nxt   = SQ_REPLAY;
      plan.pend  = 1'b1;
      plan.scan  = SC_TEXT;
    end

    if (append) begin
      if (tag_len_q < 3'd3) begin
        plan.cpo = cpo_q && (byte_in_i == comment_char(tag_len_q[1:0]));
      end
      if (tag_len_q < 3'd7) begin
        plan.len = tag_len_q + 3'd1;
      end
    end

    // ESC, LF or CR broke an unfinished construct
    if (do_break) begin
      plan.cnt  = '0;
      plan.len  = '0;
      plan.cpo  = 1'b0;
      plan.scan = (byte_in_i == CH_ESC) ? SC_ESC : SC_TEXT;
    end
  end

  // Sequencer next state
  always_comb begin
    seq_d = seq_q;
    unique case (seq_q)
      SQ_IDLE: begin
        if (accept) begin
          seq_d = plan.nxt;
        end
      end
      SQ_ERR: begin
        if (slot_free) begin
          seq_d = nl_q ? SQ_NL : SQ_IDLE;
        end
      end
      SQ_NL: begin
        if (slot_free) begin
          seq_d = SQ_IDLE;
        end
      end
      SQ_REPLAY, SQ_TAGS: begin
        if (slot_free && !in_run) begin
          seq_d = SQ_IDLE;
        end
      end
      default: seq_d = SQ_IDLE;
    endcase
  end

  // Sequencer outputs and datapath updates
  always_comb begin
    em        = 1'b0;
    em_kind   = KIND_TEXT;
    em_value  = '0;
    em_tag    = '0;
    em_err    = ERR_ESC;
    em_last   = 1'b1;
    acc_ctl   = '0;
    scan_d    = scan_q;
    pend_d    = pend_q;
    esc_cnt_d = esc_cnt_q;
    quote_d   = quote_q;
    tag_len_d = tag_len_q;
    cpo_d     = cpo_q;
    last2_d   = last2_q;
    idx_d     = idx_q;
    byte_d    = byte_q;
    nl_d      = nl_q;

    unique case (seq_q)
      SQ_IDLE: begin
        if (accept) begin
          em            = plan.em;
          em_kind       = plan.kind;
          em_value      = plan.value;
          em_err        = plan.err;
          em_last       = plan.last;
          scan_d        = plan.scan;
          pend_d        = plan.pend;
          esc_cnt_d     = plan.cnt;
          quote_d       = plan.quote;
          tag_len_d     = plan.len;
          cpo_d         = plan.cpo;
          last2_d       = plan.last2;
          byte_d        = byte_in_i;
          nl_d          = plan.nl;
          acc_ctl.clear = 1'b1;
          // line tags skip the '[' at entry zero
          idx_d = (plan.nxt == SQ_TAGS) ? ESC_CW'(1) : '0;
        end
      end

      SQ_ERR: begin
        em      = 1'b1;
        em_kind = KIND_ERROR;
        em_err  = ERR_TAG;
        em_last = !nl_q;
      end

      SQ_NL: begin
        em      = 1'b1;
        em_kind = KIND_NEWLINE;
      end

      SQ_REPLAY: begin
        em      = 1'b1;
        em_kind = KIND_TEXT;
        if (in_run) begin
          em_value = ram_rdata;
          em_last  = 1'b0;
          if (slot_free) begin
            idx_d = idx_q + 1'b1;
          end
        end else begin
          em_value = byte_q;
          if (slot_free) begin
            esc_cnt_d = '0;
          end
        end
      end

      SQ_TAGS: begin
        if (in_run && ram_rdata != CH_SEMI) begin
          // fold one digit, no result
          acc_ctl.step = 1'b1;
          idx_d        = idx_q + 1'b1;
        end else begin
          em      = 1'b1;
          em_last = !in_run;
          if (acc_num <= TAG_MAX) begin
            em_kind = KIND_LINE_TAG;
            em_tag  = acc_num;
          end else begin
            em_kind = KIND_ERROR;
            em_err  = ERR_LINE_TAG;
          end
          if (slot_free) begin
            acc_ctl.clear = 1'b1;
            if (in_run) begin
              idx_d = idx_q + 1'b1;
            end else begin
              esc_cnt_d = '0;
            end
          end
        end
      end

      default: ;
    endcase
  end

  // Output register: load on a result, drop once taken
  assign fire = em && slot_free;

  always_comb begin
    out_valid_d = out_valid_q;
    kind_d      = kind_q;
    value_d     = value_q;
    tag_d       = tag_q;
    err_d       = err_q;
    last_d      = last_q;
    if (fire) begin
      out_valid_d = 1'b1;
      kind_d      = em_kind;
      value_d     = em_value;
      tag_d       = em_tag;
      err_d       = em_err;
      last_d      = em_last;
    end else if (slot_free) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_q      <= SC_TEXT;
      pend_q      <= 1'b0;
      esc_cnt_q   <= '0;
      quote_q     <= '0;
      tag_len_q   <= '0;
      cpo_q       <= 1'b0;
      last2_q     <= '0;
      locked_q    <= 1'b0;
      seq_q       <= SQ_IDLE;
      idx_q       <= '0;
      nl_q        <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      scan_q      <= scan_d;
      pend_q      <= pend_d;
      esc_cnt_q   <= esc_cnt_d;
      quote_q     <= quote_d;
      tag_len_q   <= tag_len_d;
      cpo_q       <= cpo_d;
      last2_q     <= last2_d;
      seq_q       <= seq_d;
      idx_q       <= idx_d;
      nl_q        <= nl_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        locked_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers hold without reset
  always_ff @(posedge clk_i) begin
    byte_q  <= byte_d;
    kind_q  <= kind_d;
    value_q <= value_d;
    tag_q   <= tag_d;
    err_q   <= err_d;
    last_q  <= last_d;
  end

  // Escape buffer: written at the fill count, read at the sequencer index
  mte_ram #(
    .Width(8),
    .Depth(ESCAPE_DEPTH)
  ) u_esc_ram (
    .clk_i  (clk_i),
    .we_i   (accept && plan.we),
    .waddr_i(esc_cnt_q[ESC_AW-1:0]),
    .wdata_i(byte_in_i),
    .raddr_i(idx_d[ESC_AW-1:0]),
    .rdata_o(ram_rdata)
  );

  // Shared multiply-by-ten accumulator for line tag numbers
  mte_tag_acc u_tag_acc (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .ctl_i (acc_ctl),
    .char_i(ram_rdata),
    .num_o (acc_num)
  );

  assign out_valid_o  = out_valid_q;
  assign kind_o       = kind_q;
  assign value_o      = value_q;
  assign line_tag_o   = tag_q;
  assign error_code_o = err_q;
  assign last_o       = last_q;

  // Fill count never passes the buffer depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    esc_cnt_q <= ESC_CW'(ESCAPE_DEPTH))
    else $error("escape fill count beyond depth");

  // Replay read index stays within the filled part
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q == SQ_REPLAY || seq_q == SQ_TAGS) |-> idx_q <= esc_cnt_q)
    else $error("sequencer index beyond fill count");

  // Finishing a multi-result burst leaves a last result in the output register
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (seq_q != SQ_IDLE && seq_d == SQ_IDLE) |=> (out_valid_o && last_o))
    else $error("burst ended without last result");

  // A pending text run never survives into an escape
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_q == SC_ESC) |-> !pend_q)
    else $error("text run pending inside escape");

endmodule
